[hdl/hash_set_insert_search_unit_defines.svh]
// assertion macros for the hash set insert/search unit
// used by the checker bound to the top level; no other dependencies
`ifndef HASH_SET_INSERT_SEARCH_UNIT_DEFINES_SVH
`define HASH_SET_INSERT_SEARCH_UNIT_DEFINES_SVH

// property checked at every clock edge outside reset
`define HSI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// antecedent in one cycle implies consequent in the next
`define HSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/hsi_pkg.sv]
// shared types and constants of the hash set insert/search unit
// no dependencies; imported by the interfaces and all modules but the checker
package hsi_pkg;

  // width of the bucket count register
  localparam int unsigned CFG_W = 15;
  // bucket count after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 15'd10000;
  // width of a stored key
  localparam int unsigned KEY_W = 32;
  // iterations of the remainder unit, one per key bit
  localparam int unsigned DIV_STEPS = KEY_W;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_ABSENT    = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_FILL,
    S_FILL_WAIT,
    S_RD,
    S_CMP,
    S_DECIDE,
    S_DONE
  } state_e;

  // strobes from the sequencer to the bucket store
  typedef struct packed {
    logic fill_rd;
    logic fill_we;
    logic val_rd;
    logic val_we;
  } store_cmd_t;

endpackage

[hdl/hsi_req_if.sv]
// request channel of the hash set unit: opcode and key
// depends on hsi_pkg
interface hsi_req_if;
  import hsi_pkg::*;

  logic                    valid;
  logic                    ready;
  op_e                     opcode;
  logic signed [KEY_W-1:0] key_value;

  modport source (output valid, output opcode, output key_value, input ready);
  modport sink   (input valid, input opcode, input key_value, output ready);
endinterface

[hdl/hsi_rsp_if.sv]
// response channel of the hash set unit: status code
// depends on hsi_pkg
interface hsi_rsp_if;
  import hsi_pkg::*;

  logic    valid;
  logic    ready;
  status_e status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

[hdl/hsi_divider.sv]
// iterative restoring remainder unit, one quotient bit per cycle
// depends on hsi_pkg
module hsi_divider #(
  parameter int unsigned MOD_W = 15
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [hsi_pkg::KEY_W-1:0] dividend_i,
  input  logic [MOD_W-1:0]          modulus_i,
  output logic                      done_o,
  output logic [MOD_W-1:0]          rem_o
);
  import hsi_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [KEY_W-1:0] dvd_q;
  logic [MOD_W-1:0] mod_q;
  logic [MOD_W-1:0] rem_q;
  logic [MOD_W:0]   trial;
  logic [MOD_W:0]   diff;
  logic [MOD_W-1:0] rem_d;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q, dvd_q[KEY_W-1]};
    diff  = trial - {1'b0, mod_q};
    if (trial >= {1'b0, mod_q}) begin
      rem_d = diff[MOD_W-1:0];
    end else begin
      rem_d = trial[MOD_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      mod_q <= modulus_i;
      rem_q <= '0;
      cnt_q <= CNT_W'(DIV_STEPS - 1);
    end else if (busy_q) begin
      dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
      rem_q <= rem_d;
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule

[hdl/hsi_bucket_store.sv]
// bucket fill counts and slot values, with the clearing pass after reset
// depends on hsi_pkg
module hsi_bucket_store #(
  parameter int unsigned MAX_BUCKETS      = 16384,
  parameter int unsigned SLOTS_PER_BUCKET = 4,
  parameter int unsigned BKT_W            = 14,
  parameter int unsigned ADDR_W           = 16,
  parameter int unsigned FILL_W           = 3
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hsi_pkg::store_cmd_t       cmd_i,
  input  logic [BKT_W-1:0]          bucket_i,
  input  logic [FILL_W-1:0]         fill_wdata_i,
  input  logic [ADDR_W-1:0]         val_addr_i,
  input  logic [hsi_pkg::KEY_W-1:0] val_wdata_i,
  output logic [FILL_W-1:0]         fill_rdata_o,
  output logic [hsi_pkg::KEY_W-1:0] val_rdata_o,
  output logic                      clearing_o
);
  import hsi_pkg::*;

  localparam int unsigned VAL_DEPTH = MAX_BUCKETS * SLOTS_PER_BUCKET;

  logic [FILL_W-1:0] fill_mem [MAX_BUCKETS];
  logic [KEY_W-1:0]  val_mem  [VAL_DEPTH];
  logic              clr_q;
  logic [BKT_W-1:0]  clr_cnt_q;

  // clearing pass over the fill counts, one bucket per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      if (clr_cnt_q == BKT_W'(MAX_BUCKETS - 1)) begin
        clr_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + BKT_W'(1);
    end
  end

  // fill count memory
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      fill_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.fill_we) begin
      fill_mem[bucket_i] <= fill_wdata_i;
    end
    if (cmd_i.fill_rd) begin
      fill_rdata_o <= fill_mem[bucket_i];
    end
  end

  // slot value memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.val_we) begin
      val_mem[val_addr_i] <= val_wdata_i;
    end
    if (cmd_i.val_rd) begin
      val_rdata_o <= val_mem[val_addr_i];
    end
  end

  assign clearing_o = clr_q;
endmodule

[hdl/hash_set_insert_search_unit.sv]
// top level of the hash set insert/search unit: sequencer and registers
// depends on hsi_pkg, hsi_req_if, hsi_rsp_if, hsi_divider, hsi_bucket_store
//
//   channel  dir  handshake     payload
//   req_i    in   valid/ready   opcode, key_value
//   rsp_o    out  valid/ready   status
//   cfg      in   cfg_we_i      cfg_wdata_i (bucket count)
//
// a transaction first waits on the remainder unit (32 steps and done), then makes
// one read per slot on the single read port of the value memory, each compared the
// cycle after.
// after reset the fill counts of all MAX_BUCKETS buckets are cleared; req_i is not
// ready until the cycle after the clearing ends.
// a finished status waits in the output register; the next request is taken
// meanwhile, and the sequencer holds at the end only if that register is still full.
module hash_set_insert_search_unit #(
  parameter int unsigned MAX_BUCKETS      = 16384,
  parameter int unsigned SLOTS_PER_BUCKET = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hsi_pkg::CFG_W-1:0] cfg_wdata_i,
  hsi_req_if.sink                   req_i,
  hsi_rsp_if.source                 rsp_o
);
  import hsi_pkg::*;

  localparam int unsigned BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned MOD_W  = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned ADDR_W = (MAX_BUCKETS * SLOTS_PER_BUCKET > 1) ?
                                   $clog2(MAX_BUCKETS * SLOTS_PER_BUCKET) : 1;
  localparam int unsigned FILL_W = $clog2(SLOTS_PER_BUCKET + 1);

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  cfg_q;
  logic              rsp_valid_q;
  status_e           rsp_status_q;

  op_e               op_q;
  logic [KEY_W-1:0]  key_q;
  logic [BKT_W-1:0]  bucket_q;
  logic [ADDR_W-1:0] base_q;
  logic [FILL_W-1:0] fill_q;
  logic [FILL_W-1:0] slot_q;
  logic              found_q;
  status_e           status_q;

  logic [KEY_W-1:0]  key_bits;
  logic [KEY_W-1:0]  magnitude;
  logic [MOD_W-1:0]  modulus;
  logic              div_start;
  logic              div_done;
  logic [MOD_W-1:0]  div_rem;
  store_cmd_t        cmd;
  logic [ADDR_W-1:0] val_addr;
  logic [FILL_W-1:0] fill_rdata;
  logic [KEY_W-1:0]  val_rdata;
  logic              clearing;
  logic              bucket_full;
  logic              rsp_load;
  status_e           status_d;

  // magnitude as unsigned, modulus clamped to one and MAX_BUCKETS
  always_comb begin
    key_bits  = req_i.key_value;
    magnitude = key_bits[KEY_W-1] ? (~key_bits + KEY_W'(1)) : key_bits;
    if (cfg_q == '0) begin
      modulus = MOD_W'(1);
    end else if (32'(cfg_q) > 32'(MAX_BUCKETS)) begin
      modulus = MOD_W'(MAX_BUCKETS);
    end else begin
      modulus = MOD_W'(cfg_q);
    end
  end

  hsi_divider #(
    .MOD_W (MOD_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (magnitude),
    .modulus_i  (modulus),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  hsi_bucket_store #(
    .MAX_BUCKETS      (MAX_BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
    .BKT_W            (BKT_W),
    .ADDR_W           (ADDR_W),
    .FILL_W           (FILL_W)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .bucket_i     (bucket_q),
    .fill_wdata_i (fill_q + FILL_W'(1)),
    .val_addr_i   (val_addr),
    .val_wdata_i  (key_q),
    .fill_rdata_o (fill_rdata),
    .val_rdata_o  (val_rdata),
    .clearing_o   (clearing)
  );

  // outcome of the bucket walk
  always_comb begin
    bucket_full = (fill_q >= FILL_W'(SLOTS_PER_BUCKET));
    priority if (op_q == OP_SEARCH) begin
      status_d = found_q ? ST_PRESENT : ST_ABSENT;
    end else if (found_q) begin
      status_d = ST_DUPLICATE;
    end else if (bucket_full) begin
      status_d = ST_FULL;
    end else begin
      status_d = ST_INSERTED;
    end
  end

  assign rsp_load = !rsp_valid_q || rsp_o.ready;

  // sequencer: next state and strobes
  always_comb begin
    state_d     = state_q;
    div_start   = 1'b0;
    cmd         = '0;
    val_addr    = base_q + ADDR_W'(slot_q);
    req_i.ready = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        if (!clearing) state_d = S_IDLE;
      end
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) state_d = S_FILL;
      end
      S_FILL: begin
        cmd.fill_rd = 1'b1;
        state_d     = S_FILL_WAIT;
      end
      S_FILL_WAIT: begin
        state_d = S_RD;
      end
      S_RD: begin
        if (slot_q < fill_q) begin
          cmd.val_rd = 1'b1;
          state_d    = S_CMP;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_CMP: begin
        state_d = (val_rdata == key_q) ? S_DECIDE : S_RD;
      end
      S_DECIDE: begin
        val_addr = base_q + ADDR_W'(fill_q);
        if (status_d == ST_INSERTED) begin
          cmd.val_we  = 1'b1;
          cmd.fill_we = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (rsp_load) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cfg_q       <= CFG_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (state_q == S_DONE && rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        op_q  <= req_i.opcode;
        key_q <= req_i.key_value;
      end
      S_DIV: begin
        bucket_q <= BKT_W'(div_rem);
      end
      S_FILL: begin
        base_q  <= ADDR_W'(bucket_q) * ADDR_W'(SLOTS_PER_BUCKET);
        slot_q  <= '0;
        found_q <= 1'b0;
      end
      S_FILL_WAIT: begin
        fill_q <= fill_rdata;
      end
      S_CMP: begin
        if (val_rdata == key_q) begin
          found_q <= 1'b1;
        end else begin
          slot_q <= slot_q + FILL_W'(1);
        end
      end
      S_DECIDE: begin
        status_q <= status_d;
      end
      S_DONE: begin
        if (rsp_load) rsp_status_q <= status_q;
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.status = rsp_status_q;
endmodule

[hdl/hsi_checker.sv]
// port-level checks of the hash set unit, bound to the top level
// depends on hash_set_insert_search_unit_defines.svh
`include "hash_set_insert_search_unit_defines.svh"

module hsi_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [2:0] rsp_status_i
);
  logic [1:0] outst_q;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  // transactions taken whose status has not been delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else if (req_fire && !rsp_fire) begin
      outst_q <= outst_q + 2'd1;
    end else if (rsp_fire && !req_fire) begin
      outst_q <= outst_q - 2'd1;
    end
  end

  // one request in work at a time
  `HSI_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, req_fire, !req_ready_i, "ready after request")
  // no status without a request behind it
  `HSI_ASSERT(a_rsp_has_req, clk_i, rst_ni, rsp_valid_i |-> (outst_q != 2'd0), "spurious status")
  // at most one in work plus one waiting
  `HSI_ASSERT(a_outst_bound, clk_i, rst_ni, outst_q != 2'd3, "too many requests taken")
  // stalled status holds
  `HSI_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_status_i), "status dropped")
endmodule

bind hash_set_insert_search_unit hsi_checker u_hsi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status)
);

[test/tb_hash_set_insert_search_unit.sv]
`timescale 1ns / 100ps
// self-checking testbench of the hash set insert/search unit: directed and random transactions
// depends on hsi_pkg, hsi_req_if, hsi_rsp_if and the hash_set_insert_search_unit rtl
module tb_hash_set_insert_search_unit;
  import hsi_pkg::*;

  localparam int unsigned MAX_BUCKETS      = 16384;
  localparam int unsigned SLOTS_PER_BUCKET = 4;
  localparam int unsigned CLK_HALF         = 5;
  localparam int unsigned RESET_CYCLES     = 4;
  // clearing pass after reset plus generous slack
  localparam int unsigned QUIET_LIMIT      = 80000;
  localparam int unsigned TAIL_CYCLES      = 100;
  localparam int unsigned POOL_DEPTH       = 64;
  localparam int unsigned HOLD_OFF_CYCLES  = 400;

  typedef struct {
    op_e         op;
    logic [31:0] key;
    status_e     status;
  } status_check_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  hsi_req_if req_if ();
  hsi_rsp_if rsp_if ();

  hash_set_insert_search_unit #(
    .MAX_BUCKETS      (MAX_BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // shadow copy of the hash set
  logic [31:0]      shadow_key [MAX_BUCKETS*SLOTS_PER_BUCKET];
  int unsigned      shadow_fill [MAX_BUCKETS];
  logic [CFG_W-1:0] shadow_bucket_count = CFG_RESET;

  status_check_t    pending_status_q [$];
  logic [31:0]      key_pool [$];

  int unsigned      src_idle_pct = 36;
  int unsigned      sink_idle_pct = 87;
  int               sink_hold_left = 0;
  int unsigned      mismatches = 0;
  int unsigned      n_requests = 0;
  int unsigned      n_searches = 0;
  int unsigned      n_cfg_writes = 0;
  int unsigned      status_tally [5];

  always #(CLK_HALF) clk = ~clk;

  // predicted status of one transaction, updating the shadow set
  function automatic status_e predict_set_status(op_e op, logic [31:0] key);
    int unsigned modulus;
    int unsigned bucket;
    int unsigned base;
    int unsigned i;
    logic [31:0] magnitude;
    bit          found;
    status_e     st;
    modulus = shadow_bucket_count;
    if (modulus == 0) modulus = 1;
    if (modulus > MAX_BUCKETS) modulus = MAX_BUCKETS;
    // unsigned magnitude, the most negative key gives 2^31
    magnitude = key[31] ? (~key + 32'd1) : key;
    bucket = magnitude % modulus;
    base = bucket * SLOTS_PER_BUCKET;
    found = 1'b0;
    for (i = 0; i < shadow_fill[bucket]; i++) begin
      if (shadow_key[base + i] == key) found = 1'b1;
    end
    if (op == OP_SEARCH) begin
      st = found ? ST_PRESENT : ST_ABSENT;
    end else if (found) begin
      st = ST_DUPLICATE;
    end else if (shadow_fill[bucket] >= SLOTS_PER_BUCKET) begin
      st = ST_FULL;
    end else begin
      shadow_key[base + shadow_fill[bucket]] = key;
      shadow_fill[bucket]++;
      st = ST_INSERTED;
    end
    return st;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // offer one request, record its predicted status once accepted
  task automatic send_request(input op_e op, input logic [31:0] key);
    status_check_t entry;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.opcode    <= op;
    req_if.key_value <= key;
    do @(posedge clk); while (!req_if.ready);
    entry.op     = op;
    entry.key    = key;
    entry.status = predict_set_status(op, key);
    pending_status_q.push_back(entry);
    status_tally[entry.status]++;
    n_requests++;
    if (op == OP_SEARCH) n_searches++;
    if (op == OP_INSERT) begin
      key_pool.push_back(key);
      if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
    end
  endtask

  // stop offering and wait for every outstanding status
  task automatic wait_for_idle();
    req_if.valid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_bucket_count(input logic [CFG_W-1:0] count);
    wait_for_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_bucket_count = count;
    n_cfg_writes++;
  endtask

  // mix of recent keys, small magnitudes, extremes and full random
  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        if (key_pool.size() > 0) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else k = $urandom;
      end
      3, 4: begin
        k = $urandom_range(0, 200);
        if ($urandom_range(0, 1)) k = ~k + 32'd1;
      end
      5: begin
        case ($urandom_range(0, 4))
          0: k = 32'h0000_0000;
          1: k = 32'hFFFF_FFFF;
          2: k = 32'h7FFF_FFFF;
          3: k = 32'h8000_0000;
          default: k = 32'h8000_0001;
        endcase
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  // empty table under the reset bucket count: key extremes and basic outcomes
  task automatic test_default_count();
    send_request(OP_SEARCH, 32'h0000_0000);
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_INSERT, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h0000_0001);
    send_request(OP_SEARCH, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h7FFF_FFFF);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_SEARCH, 32'h8000_0000);
    send_request(OP_SEARCH, 32'h8000_0001);
    send_request(OP_SEARCH, 32'h7FFF_FFFF);
  endtask

  // zero count means one bucket: fill it, overflow it, and lose keys hashed before
  task automatic test_full_bucket();
    write_bucket_count('0);
    send_request(OP_INSERT, 32'd2);
    send_request(OP_INSERT, 32'd3);
    send_request(OP_INSERT, 32'd4);
    send_request(OP_INSERT, 32'd5);
    send_request(OP_INSERT, 32'd3);
    send_request(OP_SEARCH, 32'd4);
    send_request(OP_SEARCH, 32'd5);
    send_request(OP_SEARCH, 32'hFFFF_FFFF);
  endtask

  // receiver holds off while the sender keeps offering, input must stall
  task automatic test_input_backpressure();
    int unsigned n;
    write_bucket_count(CFG_W'(MAX_BUCKETS));
    src_idle_pct = 0;
    sink_hold_left = HOLD_OFF_CYCLES;
    for (n = 0; n < 12; n++) begin
      send_request($urandom_range(0, 1) ? OP_SEARCH : OP_INSERT, pick_key());
    end
    wait_for_idle();
  endtask

  // random traffic under a schedule of bucket counts, extremes included
  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
                                     input int unsigned per_count);
    logic [CFG_W-1:0] counts [6];
    int unsigned      c;
    int unsigned      n;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    counts = '{CFG_W'(MAX_BUCKETS), 15'd5, 15'h7FFF, 15'd1, 15'd200,
               CFG_W'($urandom_range(2, 20000))};
    for (c = 0; c < 6; c++) begin
      write_bucket_count(counts[c]);
      for (n = 0; n < per_count; n++) begin
        send_request(($urandom_range(0, 99) < 55) ? OP_INSERT : OP_SEARCH, pick_key());
      end
    end
    wait_for_idle();
  endtask

  // response driver: random ready, or a counted hold-off
  initial begin : sink_driver
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        sink_hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // compare each status transaction with the oldest prediction
  always @(posedge clk) begin
    status_check_t head;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_status_q.size() == 0) begin
        report_mismatch($sformatf("status %0d with no request outstanding", rsp_if.status));
      end else begin
        head = pending_status_q.pop_front();
        if (rsp_if.status !== head.status) begin
          report_mismatch($sformatf("%s key %h: status %0d, predicted %s",
                                    head.op.name(), head.key, rsp_if.status,
                                    head.status.name()));
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transaction for %0d cycles, %0d status(es) outstanding",
             QUIET_LIMIT, pending_status_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    req_if.valid     <= 1'b0;
    req_if.opcode    <= OP_INSERT;
    req_if.key_value <= '0;
    foreach (status_tally[s]) status_tally[s] = 0;
    foreach (shadow_fill[b]) shadow_fill[b] = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_default_count();
    test_full_bucket();
    test_input_backpressure();
    test_random_traffic(36, 87, 40);
    test_random_traffic(87, 36, 40);
    test_random_traffic(0, 0, 40);

    wait_for_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d searches) over %0d bucket count writes",
             n_requests, n_searches, n_cfg_writes);
    $display("outcomes inserted/duplicate/present/absent/full: %0d/%0d/%0d/%0d/%0d, %0d mismatches",
             status_tally[ST_INSERTED], status_tally[ST_DUPLICATE], status_tally[ST_PRESENT],
             status_tally[ST_ABSENT], status_tally[ST_FULL], mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
